/* rtl/msdh_pkg.sv */
`timescale 1ns / 1ps

package msdh_pkg;

   localparam int NUM_SWITCHES = 8;

   localparam int LEVEL_W   = 8;
   localparam int CHANGED_W = 8;
   localparam int STATES_W  = 16;
   localparam int TICK_W    = 16;
   localparam int ACTIVE_W  = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = CHANGED_W + STATES_W;

   localparam logic [TICK_W-1:0]   DEBOUNCE_RESET = 16'd5;
   localparam logic [TICK_W-1:0]   HOLD_RESET     = 16'd100;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET   = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_RELOAD = 2'd0,
      CSR_HOLD_TICKS      = 2'd1,
      CSR_ACTIVE_LEVELS   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_RELEASED = 2'd1,
      ST_PRESSED  = 2'd2,
      ST_HOLD     = 2'd3
   } state_type;

   // What one lane reports for the tick being taken.
   typedef struct packed {
      logic      event_hit;
      state_type state;
   } lane_out_type;

endpackage

/* rtl/msdh_lane.sv */
`timescale 1ns / 1ps

module msdh_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              tick_en,
   input  logic                              level,
   input  logic                              active_level,
   input  logic [msdh_pkg::TICK_W-1:0]       debounce_reload,
   input  logic [msdh_pkg::TICK_W-1:0]       hold_ticks,
   output msdh_pkg::lane_out_type            lane_out
);

   msdh_pkg::state_type             state_ff, state_in;
   logic [msdh_pkg::TICK_W-1:0]     dcnt_ff, dcnt_in;
   logic [msdh_pkg::TICK_W-1:0]     hcnt_ff, hcnt_in;
   logic [msdh_pkg::TICK_W-1:0]     dcnt_dec, hcnt_dec;
   logic                            active;

   assign active   = (level == active_level);
   assign dcnt_dec = dcnt_ff - 1'b1;
   assign hcnt_dec = hcnt_ff - 1'b1;

   always_comb begin
      state_in = state_ff;
      dcnt_in  = dcnt_ff;
      hcnt_in  = hcnt_ff;
      if (active) begin
         unique case (state_ff)
            msdh_pkg::ST_IDLE, msdh_pkg::ST_RELEASED: begin
               // An idle switch may pass straight through released to pressed.
               state_in = msdh_pkg::ST_RELEASED;
               dcnt_in  = dcnt_dec;
               if (dcnt_dec == '0) begin
                  state_in = msdh_pkg::ST_PRESSED;
                  dcnt_in  = debounce_reload;
               end
            end
            msdh_pkg::ST_PRESSED: begin
               hcnt_in = hcnt_dec;
               if (hcnt_dec == '0) begin
                  state_in = msdh_pkg::ST_HOLD;
                  hcnt_in  = hold_ticks;
               end
               dcnt_in = debounce_reload;
            end
            msdh_pkg::ST_HOLD: begin
               dcnt_in = debounce_reload;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end else begin
         unique case (state_ff)
            msdh_pkg::ST_PRESSED: begin
               dcnt_in = dcnt_dec;
               if (dcnt_dec == '0) begin
                  state_in = msdh_pkg::ST_RELEASED;
                  dcnt_in  = debounce_reload;
               end
               hcnt_in = hold_ticks;
            end
            msdh_pkg::ST_HOLD: begin
               // The hold counter is left alone while a held switch is released.
               dcnt_in = dcnt_dec;
               if (dcnt_dec == '0) begin
                  state_in = msdh_pkg::ST_RELEASED;
                  dcnt_in  = debounce_reload;
               end
            end
            msdh_pkg::ST_RELEASED: begin
               dcnt_in  = debounce_reload;
               state_in = msdh_pkg::ST_IDLE;
            end
            msdh_pkg::ST_IDLE: begin
               state_in = state_ff;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // Idle and released swap quietly; every other change is reported.
   always_comb begin
      lane_out.state     = state_in;
      lane_out.event_hit =
         ((state_in == msdh_pkg::ST_PRESSED) && (state_ff != msdh_pkg::ST_PRESSED)) ||
         ((state_in == msdh_pkg::ST_HOLD) && (state_ff != msdh_pkg::ST_HOLD)) ||
         ((state_in == msdh_pkg::ST_RELEASED) &&
          ((state_ff == msdh_pkg::ST_PRESSED) || (state_ff == msdh_pkg::ST_HOLD)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msdh_pkg::ST_IDLE;
         dcnt_ff  <= msdh_pkg::DEBOUNCE_RESET;
         hcnt_ff  <= msdh_pkg::HOLD_RESET;
      end else if (tick_en) begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
         hcnt_ff  <= hcnt_in;
      end
   end

   a_hold_from_pressed: assert property (@(posedge clock) disable iff (reset)
      (tick_en && (state_in == msdh_pkg::ST_HOLD) && (state_ff != msdh_pkg::ST_HOLD))
      |-> (state_ff == msdh_pkg::ST_PRESSED))
      else $error("hold entered from a state other than pressed");

   a_idle_inactive_still: assert property (@(posedge clock) disable iff (reset)
      (tick_en && !active && (state_ff == msdh_pkg::ST_IDLE))
      |=> ((state_ff == msdh_pkg::ST_IDLE) && $stable(dcnt_ff) && $stable(hcnt_ff)))
      else $error("idle switch changed without an active level");

   a_pressed_reloads_debounce: assert property (@(posedge clock) disable iff (reset)
      (tick_en && active && (state_ff == msdh_pkg::ST_PRESSED))
      |=> (dcnt_ff == $past(debounce_reload)))
      else $error("debounce counter not reloaded while pressed");

endmodule

/* rtl/msdh_merge.sv */
`timescale 1ns / 1ps

module msdh_merge (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   tick_en,
   input  msdh_pkg::lane_out_type                 lane_out [msdh_pkg::NUM_SWITCHES],
   output logic                                   take_ready,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [msdh_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   logic [msdh_pkg::CHANGED_W-1:0]   changed;
   logic [msdh_pkg::STATES_W-1:0]    states;
   logic [msdh_pkg::RSP_DATA_W-1:0]  word;

   logic                             out_valid_ff, out_valid_in;
   logic [msdh_pkg::RSP_DATA_W-1:0]  out_data_ff, out_data_in;
   logic                             skid_valid_ff, skid_valid_in;
   logic [msdh_pkg::RSP_DATA_W-1:0]  skid_data_ff, skid_data_in;
   logic                             pop;

   // Switches beyond the output width are dropped from the result.
   always_comb begin
      changed = '0;
      states  = '0;
      for (int n = 0; n < msdh_pkg::NUM_SWITCHES; n++) begin
         if (n < msdh_pkg::CHANGED_W) begin
            changed[n]       = lane_out[n].event_hit;
            states[2*n +: 2] = lane_out[n].state;
         end
      end
   end

   assign word       = {states, changed};
   assign take_ready = !skid_valid_ff;
   assign pop        = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (tick_en) begin
            out_data_in = word;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (tick_en) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = word;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (tick_en && out_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("result taken while output stalled was not kept");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry did not move to the output");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !tick_en)
      else $error("tick taken with both entries full");

endmodule

/* rtl/multi_switch_debounce_hold.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// req_     | in        | tdata[7:0] switch_levels
// rsp_     | out       | tdata[7:0] changed_mask, tdata[23:8] switch_states
// csr_     | in        | index 0 debounce reload, 1 hold_ticks, 2 active_levels
//
// One tick per cycle while req_tready is high: every switch has its own lane, all lanes update together.
// Each result is registered in the output register, or in the second entry while rsp is stalled.
// A two-entry output buffer lets one more tick be taken while rsp is stalled;
// req_tready drops only once both entries are full.
// Reset is synchronous; it loads the register defaults and puts every switch idle.

module multi_switch_debounce_hold (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [msdh_pkg::LEVEL_W-1:0]         req_tdata,  // [7:0] switch_levels
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [msdh_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [7:0] changed_mask,
                                                            // [23:8] switch_states
   input  logic                                 csr_we,
   input  logic [msdh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msdh_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [msdh_pkg::TICK_W-1:0]    debounce_reload_ff;
   logic [msdh_pkg::TICK_W-1:0]    hold_ticks_ff;
   logic [msdh_pkg::ACTIVE_W-1:0]  active_levels_ff;
   logic                           tick_en;
   logic                           take_ready;
   msdh_pkg::lane_out_type         lane_out [msdh_pkg::NUM_SWITCHES];

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_reload_ff <= msdh_pkg::DEBOUNCE_RESET;
         hold_ticks_ff      <= msdh_pkg::HOLD_RESET;
         active_levels_ff   <= msdh_pkg::ACTIVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            msdh_pkg::CSR_DEBOUNCE_RELOAD: debounce_reload_ff <= csr_wdata;
            msdh_pkg::CSR_HOLD_TICKS:      hold_ticks_ff      <= csr_wdata;
            msdh_pkg::CSR_ACTIVE_LEVELS:
               active_levels_ff <= csr_wdata[msdh_pkg::ACTIVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = take_ready;
   assign tick_en    = req_tvalid && take_ready;

   for (genvar n = 0; n < msdh_pkg::NUM_SWITCHES; n++) begin : g_lane
      logic level_bit;
      logic active_bit;
      // Switches beyond the input width see zero for both bits.
      if (n < msdh_pkg::LEVEL_W) begin : g_wired
         assign level_bit  = req_tdata[n];
         assign active_bit = active_levels_ff[n];
      end else begin : g_unwired
         assign level_bit  = 1'b0;
         assign active_bit = 1'b0;
      end

      msdh_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .tick_en         (tick_en),
         .level           (level_bit),
         .active_level    (active_bit),
         .debounce_reload (debounce_reload_ff),
         .hold_ticks      (hold_ticks_ff),
         .lane_out        (lane_out[n])
      );
   end

   msdh_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (tick_en),
      .lane_out   (lane_out),
      .take_ready (take_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
